>>> sv/cssum_pkg.sv
// cssum_pkg: shared widths, codes and types of the cumulative sum row unit
// used by the channel interfaces and every cssum module
package cssum_pkg;

   localparam int VALUE_W     = 32;
   localparam int SUM_OUT_W   = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REVERSE   = 1'b0,
      CSR_EXCLUSIVE = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      KIND_FWD   = 1'b0,
      KIND_DRAIN = 1'b1
   } entry_kind_type;

   typedef enum logic [0:0] {
      BACK_IDLE = 1'b0,
      BACK_EMIT = 1'b1
   } back_state_type;

   typedef struct packed {
      logic reverse;
      logic exclusive;
   } mode_type;

endpackage

>>> sv/cssum_if.sv
// cssum_req_if / cssum_rsp_if: valid-ready channels of the cumulative sum row unit
// depends on cssum_pkg for the payload widths
interface cssum_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [cssum_pkg::VALUE_W-1:0] value;
   logic                                 row_end;

   modport source (output valid, output value, output row_end, input ready);
   modport sink   (input valid, input value, input row_end, output ready);
endinterface

interface cssum_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [cssum_pkg::SUM_OUT_W-1:0] sum_out;
   logic                                   last_out;

   modport source (output valid, output sum_out, output last_out, input ready);
   modport sink   (input valid, input sum_out, input last_out, output ready);
endinterface

>>> sv/cssum_front.sv
// cssum_front: accepts elements, holds the mode registers and the running sum,
// emits forward results or drain commands into the queue; uses cssum_pkg, cssum_req_if
module cssum_front #(
   parameter int DATA_WIDTH = 32,
   parameter int MAX_ROW    = 64,
   parameter int AW         = 6,
   parameter int CW         = 7,
   parameter int EW         = 2 + CW + DATA_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   cssum_req_if.sink                        req_bus,
   input  logic                             csr_wr_en,
   input  logic [cssum_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cssum_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output cssum_pkg::mode_type              mode,
   output logic                             q_push,
   output logic [EW-1:0]                    q_push_data,
   input  logic                             q_full,
   output logic                             mem_wr_en,
   output logic [AW-1:0]                    mem_wr_addr,
   output logic [DATA_WIDTH-1:0]            mem_wr_data,
   input  logic                             drain_done
);
   import cssum_pkg::*;

   mode_type              mode_ff, mode_in;
   logic [DATA_WIDTH-1:0] run_ff, run_in;
   logic [CW-1:0]         row_cnt_ff, row_cnt_in;
   logic                  busy_ff, busy_in;

   logic                  accept;
   logic [DATA_WIDTH-1:0] v_dw;
   logic [DATA_WIDTH-1:0] sum_new;
   logic [CW-1:0]         cnt_next;
   logic                  close;
   entry_kind_type        kind;
   logic                  last;
   logic [DATA_WIDTH-1:0] entry_data;

   assign req_bus.ready = !busy_ff && !q_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign mode          = mode_ff;

   // sign-extend or wrap the element to the data width
   assign v_dw     = DATA_WIDTH'(req_bus.value);
   assign sum_new  = run_ff + v_dw;
   assign cnt_next = row_cnt_ff + CW'(1);
   assign close    = req_bus.row_end || (cnt_next == CW'(MAX_ROW));

   always_comb begin
      mode_in    = mode_ff;
      run_in     = run_ff;
      row_cnt_in = row_cnt_ff;
      busy_in    = busy_ff && !drain_done;
      q_push     = 1'b0;
      kind       = KIND_FWD;
      last       = req_bus.row_end;
      entry_data = mode_ff.exclusive ? run_ff : sum_new;
      mem_wr_en  = 1'b0;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_REVERSE:   mode_in.reverse   = csr_wr_data[0];
            CSR_EXCLUSIVE: mode_in.exclusive = csr_wr_data[0];
            default:       mode_in           = mode_ff;
         endcase
         run_in     = '0;
         row_cnt_in = '0;
      end else if (accept) begin
         if (!mode_ff.reverse) begin
            q_push = 1'b1;
            run_in = req_bus.row_end ? '0 : sum_new;
         end else begin
            mem_wr_en = 1'b1;
            if (close) begin
               // whole row stored: hand the total and length to the back end
               q_push     = 1'b1;
               kind       = KIND_DRAIN;
               last       = 1'b1;
               entry_data = sum_new;
               busy_in    = 1'b1;
               run_in     = '0;
               row_cnt_in = '0;
            end else begin
               run_in     = sum_new;
               row_cnt_in = cnt_next;
            end
         end
      end
   end

   assign q_push_data = {kind, last, (mode_ff.reverse ? cnt_next : CW'(1)), entry_data};
   assign mem_wr_addr = row_cnt_ff[AW-1:0];
   assign mem_wr_data = v_dw;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= '0;
         run_ff     <= '0;
         row_cnt_ff <= '0;
         busy_ff    <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         run_ff     <= run_in;
         row_cnt_ff <= row_cnt_in;
         busy_ff    <= busy_in;
      end
   end

   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      row_cnt_ff < CW'(MAX_ROW))
      else $error("stored row length reached the row limit without closing");

   a_busy_no_store: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !mem_wr_en)
      else $error("row buffer written while a row drains");

endmodule

>>> sv/cssum_queue.sv
// cssum_queue: short fifo between the front and back ends
// uses cssum_pkg for the depth
module cssum_queue #(
   parameter int WIDTH = 41
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   import cssum_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    fill_ff, fill_in;

   assign full       = (fill_ff == NW'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PW'((32'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = pop  ? PW'((32'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      fill_in   = fill_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");

endmodule

>>> sv/cssum_back.sv
// cssum_back: row buffer, suffix-sum drain sequencer and output register
// uses cssum_pkg and cssum_rsp_if
module cssum_back #(
   parameter int DATA_WIDTH = 32,
   parameter int MAX_ROW    = 64,
   parameter int AW         = 6,
   parameter int CW         = 7,
   parameter int EW         = 2 + CW + DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cssum_pkg::mode_type   mode,
   input  logic                  q_valid,
   input  logic [EW-1:0]         q_data,
   output logic                  q_pop,
   input  logic                  mem_wr_en,
   input  logic [AW-1:0]         mem_wr_addr,
   input  logic [DATA_WIDTH-1:0] mem_wr_data,
   output logic                  drain_done,
   cssum_rsp_if.source           rsp_bus
);
   import cssum_pkg::*;

   logic [DATA_WIDTH-1:0] row_mem [MAX_ROW];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;

   back_state_type        state_ff, state_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic                  out_valid_ff, out_valid_in;
   logic [DATA_WIDTH-1:0] out_sum_ff, out_sum_in;
   logic                  out_last_ff, out_last_in;

   entry_kind_type        head_kind;
   logic                  head_last;
   logic [CW-1:0]         head_cnt;
   logic [DATA_WIDTH-1:0] head_sum;
   logic                  out_free;
   logic                  load_out;
   logic [DATA_WIDTH-1:0] diff;
   logic                  final_idx;

   assign head_sum  = q_data[DATA_WIDTH-1:0];
   assign head_cnt  = q_data[DATA_WIDTH+CW-1:DATA_WIDTH];
   assign head_last = q_data[DATA_WIDTH+CW];
   assign head_kind = entry_kind_type'(q_data[DATA_WIDTH+CW+1]);

   assign out_free  = !out_valid_ff || rsp_bus.ready;
   // acc holds the suffix sum from the current index to the row end
   assign diff      = acc_ff - rd_data_ff;
   assign final_idx = (CW'(idx_ff) + CW'(1)) == head_cnt;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      acc_in      = acc_ff;
      q_pop       = 1'b0;
      drain_done  = 1'b0;
      load_out    = 1'b0;
      out_sum_in  = out_sum_ff;
      out_last_in = out_last_ff;
      rd_en       = 1'b0;
      rd_addr     = idx_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (q_valid) begin
               if (head_kind == KIND_FWD) begin
                  if (out_free) begin
                     load_out    = 1'b1;
                     out_sum_in  = head_sum;
                     out_last_in = head_last;
                     q_pop       = 1'b1;
                  end
               end else begin
                  // start the drain: row total first, element zero read ahead
                  acc_in   = head_sum;
                  idx_in   = '0;
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = BACK_EMIT;
               end
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               load_out    = 1'b1;
               out_sum_in  = mode.exclusive ? diff : acc_ff;
               out_last_in = final_idx;
               acc_in      = diff;
               if (final_idx) begin
                  q_pop      = 1'b1;
                  drain_done = 1'b1;
                  state_in   = BACK_IDLE;
               end else begin
                  idx_in  = idx_ff + AW'(1);
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + AW'(1);
               end
            end
         end
         default: state_in = BACK_IDLE;
      endcase
      out_valid_in = load_out ? 1'b1 : (out_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         row_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= row_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      out_sum_ff  <= out_sum_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.sum_out  = SUM_OUT_W'($signed(out_sum_ff));
   assign rsp_bus.last_out = out_last_ff;

   a_emit_has_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_EMIT) |-> (q_valid && head_kind == KIND_DRAIN))
      else $error("drain running without its command at the queue head");

   a_idx_in_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_EMIT) |-> (CW'(idx_ff) < head_cnt))
      else $error("drain index ran past the stored row");

endmodule

>>> sv/cumulative_sum_row_unit.sv
// cumulative_sum_row_unit: top level of the row-wise cumulative sum block
// depends on cssum_pkg, cssum_if, cssum_front, cssum_queue, cssum_back
//
//  channel   direction  transfer on          payload
//  req_bus   in         valid & ready        value (s32), row_end
//  rsp_bus   out        valid & ready        sum_out (s32), last_out
//  csr_*     in         csr_wr_en            csr_index, csr_wr_data
//
// forward mode: one element per cycle in, one result per cycle out, unless rsp_bus stalls.
// reverse mode: the row fills the buffer at one element per cycle; the closing element
// starts a drain (one buffer read port, one result per cycle unless rsp_bus stalls),
// and req_bus.ready stays low from that element until the last result is loaded.
// reset is synchronous; the row buffer needs no clearing pass.
// a stalled rsp_bus backs up through the output register and the two-entry queue.
module cumulative_sum_row_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int MAX_ROW    = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   cssum_req_if.sink                         req_bus,
   cssum_rsp_if.source                       rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [cssum_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cssum_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import cssum_pkg::*;

   localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
   localparam int CW = $clog2(MAX_ROW + 1);
   localparam int EW = 2 + CW + DATA_WIDTH;

   mode_type              mode;
   logic                  q_push;
   logic [EW-1:0]         q_push_data;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_valid;
   logic [EW-1:0]         q_data;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic                  drain_done;

   cssum_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .MAX_ROW    (MAX_ROW),
      .AW         (AW),
      .CW         (CW),
      .EW         (EW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .mode        (mode),
      .q_push      (q_push),
      .q_push_data (q_push_data),
      .q_full      (q_full),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .drain_done  (drain_done)
   );

   cssum_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_data)
   );

   cssum_back #(
      .DATA_WIDTH (DATA_WIDTH),
      .MAX_ROW    (MAX_ROW),
      .AW         (AW),
      .CW         (CW),
      .EW         (EW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .mode        (mode),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .drain_done  (drain_done),
      .rsp_bus     (rsp_bus)
   );

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking bench for cumulative_sum_row_unit, forward and reverse row scans
// depends on cssum_pkg, cssum_if and the cumulative_sum_row_unit rtl
// a scoreboard class predicts every sum; plain tasks drive elements and register writes
`timescale 1ns / 100ps

typedef struct packed {
   logic signed [cssum_pkg::SUM_OUT_W-1:0] sum;
   logic                                   row_last;
} sum_item_type;

class cumsum_scoreboard;
   localparam int ROW_DEPTH = 64;

   logic                                   reverse_on;
   logic                                   exclusive_on;
   logic signed [cssum_pkg::SUM_OUT_W-1:0] prefix_sum;
   logic signed [cssum_pkg::SUM_OUT_W-1:0] row_buf [ROW_DEPTH];
   int                                     row_len;
   sum_item_type                           pending_sums [$];
   int                                     errors;

   function new();
      reverse_on   = 1'b0;
      exclusive_on = 1'b0;
      prefix_sum   = '0;
      row_len      = 0;
      errors       = 0;
   endfunction

   // any register write drops the partial row
   function void set_register(cssum_pkg::csr_index_type idx, logic data);
      case (idx)
         cssum_pkg::CSR_REVERSE:   reverse_on = data;
         cssum_pkg::CSR_EXCLUSIVE: exclusive_on = data;
         default: return;
      endcase
      prefix_sum = '0;
      row_len    = 0;
   endfunction

   function void add_element(logic signed [cssum_pkg::VALUE_W-1:0] v, logic row_end);
      logic signed [cssum_pkg::SUM_OUT_W-1:0] acc;
      logic signed [cssum_pkg::SUM_OUT_W-1:0] suffix [ROW_DEPTH];
      sum_item_type                           item;
      if (!reverse_on) begin
         item.sum      = exclusive_on ? prefix_sum : prefix_sum + v;
         item.row_last = row_end;
         pending_sums.push_back(item);
         prefix_sum = row_end ? '0 : prefix_sum + v;
         return;
      end
      row_buf[row_len] = v;
      row_len++;
      // a full buffer closes the row even without row_end
      if (!row_end && row_len < ROW_DEPTH)
         return;
      acc = '0;
      for (int i = row_len - 1; i >= 0; i--) begin
         if (exclusive_on) begin
            suffix[i] = acc;
            acc       = acc + row_buf[i];
         end else begin
            acc       = acc + row_buf[i];
            suffix[i] = acc;
         end
      end
      for (int i = 0; i < row_len; i++) begin
         item.sum      = suffix[i];
         item.row_last = (i == row_len - 1);
         pending_sums.push_back(item);
      end
      row_len = 0;
   endfunction

   task report_mismatch(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
   endtask

   function bit last_ok(logic got, logic want);
      return got === want;
   endfunction

   task check_sum(logic signed [cssum_pkg::SUM_OUT_W-1:0] sum, logic row_last);
      sum_item_type want;
      if (pending_sums.size() == 0) begin
         report_mismatch($sformatf("result %0d with no sum pending", sum));
         return;
      end
      want = pending_sums.pop_front();
      if (sum !== want.sum)
         report_mismatch($sformatf("sum_out got %0d expected %0d", sum, want.sum));
      if (last_ok(row_last, want.row_last) == 0)
         report_mismatch($sformatf("last_out got %b expected %b", row_last, want.row_last));
   endtask
endclass

module tb_top;
   import cssum_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_GAP   = 12;
   localparam int PHASE_ITEMS = 80;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   cssum_req_if req_bus ();
   cssum_rsp_if rsp_bus ();

   cumulative_sum_row_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   cumsum_scoreboard sb = new();

   int unsigned req_transfers = 0;
   int unsigned cycles        = 0;
   int          stall_left    = 0;
   bit          no_idle       = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // transfers are seen with the values from before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.add_element(req_bus.value, req_bus.row_end);
            req_transfers++;
         end
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_sum(rsp_bus.sum_out, rsp_bus.last_out);
      end
   end

   // result side back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_element(input logic signed [VALUE_W-1:0] v, input logic row_end);
      int unsigned seen;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      seen = req_transfers;
      req_bus.valid   <= 1'b1;
      req_bus.value   <= v;
      req_bus.row_end <= row_end;
      do @(negedge clock); while (req_transfers == seen);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (sb.pending_sums.size() != 0) @(negedge clock);
      repeat (DRAIN_GAP) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic data);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      sb.set_register(idx, data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 200)) - 100;
         3: return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
         default: return $signed($urandom);
      endcase
   endfunction

   // rows of random length; the last row may stay open and is dropped by the next write
   task automatic run_rows(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
         for (int i = 0; i < len && sent < n_items; i++) begin
            send_element(pick_value(), i == len - 1);
            sent++;
         end
      end
   endtask

   initial begin
      logic [1:0] modes [6];
      modes = '{2'b00, 2'b10, 2'b01, 2'b11, 2'b10, 2'b00};

      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_REVERSE;
      csr_wr_data     = 1'b0;
      req_bus.valid   = 1'b0;
      req_bus.value   = '0;
      req_bus.row_end = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // forward inclusive: wrap through the extremes
      send_element(32'sh7fffffff, 1'b0);
      send_element(32'sd1, 1'b0);
      send_element(32'sh80000000, 1'b0);
      send_element(-32'sd1, 1'b1);
      send_element(32'sd0, 1'b1);

      // forward exclusive, then a partial row dropped by a write
      write_reg(CSR_EXCLUSIVE, 1'b1);
      send_element(32'sh7fffffff, 1'b0);
      send_element(32'sh7fffffff, 1'b0);
      send_element(32'sh80000000, 1'b1);
      send_element(32'sd5, 1'b0);

      // reverse exclusive, single element row gives an empty sum
      write_reg(CSR_REVERSE, 1'b1);
      send_element(32'sh80000000, 1'b0);
      send_element(32'sh7fffffff, 1'b0);
      send_element(32'sd1, 1'b1);
      send_element(32'sd42, 1'b1);
      send_element(32'sd7, 1'b0);
      send_element(32'sd9, 1'b0);

      // reverse inclusive, stored partial row dropped first
      write_reg(CSR_EXCLUSIVE, 1'b0);
      send_element(-32'sd1, 1'b0);
      send_element(32'sh7fffffff, 1'b1);
      send_element(32'sh55555555, 1'b0);
      send_element(32'shaaaaaaaa, 1'b1);

      foreach (modes[p]) begin
         write_reg(CSR_REVERSE, modes[p][1]);
         write_reg(CSR_EXCLUSIVE, modes[p][0]);
         if (p == 5)
            no_idle = 1'b1;
         run_rows(PHASE_ITEMS);
      end

      wait_idle();
      if (sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
